// ===== hdl/utf8_printable_checker_unit_defines.svh =====
// Assertion macros used by the checker module.
`ifndef UTF8_PRINTABLE_CHECKER_UNIT_DEFINES_SVH
`define UTF8_PRINTABLE_CHECKER_UNIT_DEFINES_SVH

// Check a property on every rising clk edge outside reset.
`define UTF8PC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clk edge, reset included.
`define UTF8PC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/utf8pc_pkg.sv =====
package utf8pc_pkg;

    // Bytes of the message inspected for a high (>= 0x80) byte.
    localparam int PREFIX_PROBE_LEN = 4;
    localparam int PREFIX_CNT_W     = $clog2(PREFIX_PROBE_LEN + 1);

    // Class queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Byte values and masks.
    localparam logic [7:0] BYTE_20   = 8'h20;
    localparam logic [7:0] BYTE_7E   = 8'h7e;
    localparam logic [7:0] MASK_C0   = 8'hc0;
    localparam logic [7:0] MASK_E0   = 8'he0;
    localparam logic [7:0] MASK_F0   = 8'hf0;
    localparam logic [7:0] MASK_F8   = 8'hf8;
    localparam logic [7:0] MASK_FE   = 8'hfe;
    localparam logic [7:0] BYTE_80   = 8'h80;
    localparam logic [7:0] BYTE_8F   = 8'h8f;
    localparam logic [7:0] BYTE_A0   = 8'ha0;
    localparam logic [7:0] BYTE_BE   = 8'hbe;
    localparam logic [7:0] BYTE_BF   = 8'hbf;
    localparam logic [7:0] BYTE_C0   = 8'hc0;
    localparam logic [7:0] BYTE_E0   = 8'he0;
    localparam logic [7:0] BYTE_ED   = 8'hed;
    localparam logic [7:0] BYTE_EF   = 8'hef;
    localparam logic [7:0] BYTE_F0   = 8'hf0;
    localparam logic [7:0] BYTE_F4   = 8'hf4;

    // Lead bytes that need a special check on later bytes.
    typedef enum logic [2:0] {
        TAG_OTHER,
        TAG_E0,
        TAG_ED,
        TAG_EF,
        TAG_F0,
        TAG_F4
    } lead_tag_t;

    // Pre-decoded view of one byte, as the back needs it.
    typedef struct packed {
        logic      last;
        logic      ascii_bad;   // outside 0x20..0x7E
        logic      high;        // >= 0x80
        logic      is_cont;     // 10xxxxxx
        logic [1:0] lead_len;   // continuations a good lead calls for, 0 if none
        lead_tag_t tag;
        logic      e0_low;      // 80..9F
        logic      ed_high;     // A0..BF
        logic      f0_low;      // 80..8F
        logic      f4_high;     // above 8F
        logic      is_bf;
        logic      is_be_bf;    // BE or BF
    } byte_class_t;

    // Queue to back handshake.
    typedef struct packed {
        logic        valid;
        byte_class_t cls;
    } queue_head_t;

endpackage

// ===== hdl/utf8pc_front.sv =====
module utf8pc_front
    import utf8pc_pkg::*;
(
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output byte_class_t cls
);

    always_comb
    begin
        cls.last      = last_byte;
        cls.ascii_bad = (data_byte < BYTE_20) || (data_byte > BYTE_7E);
        cls.high      = data_byte[7];
        cls.is_cont   = (data_byte & MASK_C0) == BYTE_80;
        cls.e0_low    = (data_byte & MASK_E0) == BYTE_80;
        cls.ed_high   = (data_byte & MASK_E0) == BYTE_A0;
        cls.f0_low    = (data_byte & MASK_F0) == BYTE_80;
        cls.f4_high   = data_byte > BYTE_8F;
        cls.is_bf     = data_byte == BYTE_BF;
        cls.is_be_bf  = (data_byte & MASK_FE) == BYTE_BE;

        // Leads C0/C1 are overlong and F5 and up lie past the code space.
        if (((data_byte & MASK_E0) == BYTE_C0) && ((data_byte & MASK_FE) != BYTE_C0))
        begin
            cls.lead_len = 2'd1;
        end
        else if ((data_byte & MASK_F0) == BYTE_E0)
        begin
            cls.lead_len = 2'd2;
        end
        else if (((data_byte & MASK_F8) == BYTE_F0) && (data_byte <= BYTE_F4))
        begin
            cls.lead_len = 2'd3;
        end
        else
        begin
            cls.lead_len = 2'd0;
        end

        priority if (data_byte == BYTE_E0)
        begin
            cls.tag = TAG_E0;
        end
        else if (data_byte == BYTE_ED)
        begin
            cls.tag = TAG_ED;
        end
        else if (data_byte == BYTE_EF)
        begin
            cls.tag = TAG_EF;
        end
        else if (data_byte == BYTE_F0)
        begin
            cls.tag = TAG_F0;
        end
        else if (data_byte == BYTE_F4)
        begin
            cls.tag = TAG_F4;
        end
        else
        begin
            cls.tag = TAG_OTHER;
        end
    end

endmodule

// ===== hdl/utf8pc_queue.sv =====
module utf8pc_queue
    import utf8pc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  byte_class_t push_cls,
    output logic        full,
    input  logic        pop,
    output queue_head_t head
);

    byte_class_t       entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + QPTR_W'(1);
        end
        return r;
    endfunction

    assign full       = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign head.valid = count_reg != '0;
    assign head.cls   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cls;
        end
    end

endmodule

// ===== hdl/utf8pc_back.sv =====
module utf8pc_back
    import utf8pc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  queue_head_t head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        utf8_valid,
    output logic        ascii_valid,
    output logic        printable
);

    logic [1:0]              pending_reg;
    logic [1:0]              pending_next;
    lead_tag_t               tag_reg;
    lead_tag_t               tag_next;
    logic [1:0]              lead_len_reg;
    logic [1:0]              lead_len_next;
    logic                    second_bf_reg;
    logic                    second_bf_next;
    logic                    utf8_err_reg;
    logic                    utf8_err_next;
    logic                    ascii_err_reg;
    logic                    ascii_err_next;
    logic                    high_prefix_reg;
    logic                    high_prefix_next;
    logic [PREFIX_CNT_W-1:0] prefix_cnt_reg;
    logic [PREFIX_CNT_W-1:0] prefix_cnt_next;
    logic                    out_valid_reg;
    logic                    utf8_valid_reg;
    logic                    ascii_valid_reg;
    logic                    printable_reg;
    logic                    final_err;
    byte_class_t             c;

    assign c   = head.cls;
    assign pop = head.valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        pending_next     = pending_reg;
        tag_next         = tag_reg;
        lead_len_next    = lead_len_reg;
        second_bf_next   = second_bf_reg;
        utf8_err_next    = utf8_err_reg;
        ascii_err_next   = ascii_err_reg | c.ascii_bad;
        high_prefix_next = high_prefix_reg;
        prefix_cnt_next  = prefix_cnt_reg;

        if (prefix_cnt_reg < PREFIX_CNT_W'(PREFIX_PROBE_LEN))
        begin
            high_prefix_next = high_prefix_reg | c.high;
            prefix_cnt_next  = prefix_cnt_reg + PREFIX_CNT_W'(1);
        end

        if (pending_reg != 2'd0)
        begin
            if (!c.is_cont)
            begin
                // Sequence cut short: flag it and drop what is open.
                utf8_err_next = 1'b1;
                pending_next  = 2'd0;
            end
            else
            begin
                if (pending_reg == lead_len_reg)
                begin
                    if ((tag_reg == TAG_E0 && c.e0_low) || (tag_reg == TAG_ED && c.ed_high) ||
                        (tag_reg == TAG_F0 && c.f0_low) || (tag_reg == TAG_F4 && c.f4_high))
                    begin
                        utf8_err_next = 1'b1;
                    end
                    second_bf_next = c.is_bf;
                end
                else if (pending_reg == 2'd1 && lead_len_reg == 2'd2)
                begin
                    // EF BF BE and EF BF BF are noncharacters.
                    if (tag_reg == TAG_EF && second_bf_reg && c.is_be_bf)
                    begin
                        utf8_err_next = 1'b1;
                    end
                end
                pending_next = pending_reg - 2'd1;
            end
        end
        else if (c.high)
        begin
            if (c.lead_len == 2'd0)
            begin
                utf8_err_next = 1'b1;
            end
            else
            begin
                pending_next   = c.lead_len;
                tag_next       = c.tag;
                lead_len_next  = c.lead_len;
                second_bf_next = 1'b0;
            end
        end

        final_err = utf8_err_next || (pending_next != 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg     <= 2'd0;
            tag_reg         <= TAG_OTHER;
            lead_len_reg    <= 2'd0;
            second_bf_reg   <= 1'b0;
            utf8_err_reg    <= 1'b0;
            ascii_err_reg   <= 1'b0;
            high_prefix_reg <= 1'b0;
            prefix_cnt_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (pop && c.last)
            begin
                pending_reg     <= 2'd0;
                tag_reg         <= TAG_OTHER;
                lead_len_reg    <= 2'd0;
                second_bf_reg   <= 1'b0;
                utf8_err_reg    <= 1'b0;
                ascii_err_reg   <= 1'b0;
                high_prefix_reg <= 1'b0;
                prefix_cnt_reg  <= '0;
            end
            else if (pop)
            begin
                pending_reg     <= pending_next;
                tag_reg         <= tag_next;
                lead_len_reg    <= lead_len_next;
                second_bf_reg   <= second_bf_next;
                utf8_err_reg    <= utf8_err_next;
                ascii_err_reg   <= ascii_err_next;
                high_prefix_reg <= high_prefix_next;
                prefix_cnt_reg  <= prefix_cnt_next;
            end

            if (pop && c.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && c.last)
        begin
            utf8_valid_reg  <= !final_err;
            ascii_valid_reg <= !ascii_err_next;
            printable_reg   <= !ascii_err_next || (high_prefix_next && !final_err);
        end
    end

    assign out_valid   = out_valid_reg;
    assign utf8_valid  = utf8_valid_reg;
    assign ascii_valid = ascii_valid_reg;
    assign printable   = printable_reg;

endmodule

// ===== hdl/utf8_printable_checker_unit.sv =====
// Streaming UTF-8 and printable-ASCII checker.
// Input channel (in_valid/in_ready): one message byte per transaction on data_byte,
// with last_byte high on the final byte. Messages are never empty.
// Output channel (out_valid/out_ready): one transaction per message, carrying
// utf8_valid, ascii_valid and printable, in message order.
// Throughput: one byte per cycle, sustained, while the receiver keeps up.
// The final byte's class passes through the queue, and the back registers the
// verdict in its output register as it pops that class. The front decodes each
// byte into a class word, a two-entry queue holds the classes, and the back runs
// the sequence state and sticky flags, one class per cycle while the receiver
// keeps up; the back's single state update per class sets that rate.
// When the receiver stalls, the result holds in the output register, the back
// stops popping, and the queue absorbs up to two more bytes before in_ready
// drops. Reset (rst_n low, asynchronous) empties the queue, drops any pending
// result and clears the sequence state and flags; after the final byte of a
// message the state returns to its reset values by itself.
module utf8_printable_checker_unit
    import utf8pc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       utf8_valid,
    output logic       ascii_valid,
    output logic       printable
);

    byte_class_t cls;
    queue_head_t head;
    logic        q_full;
    logic        pop;
    logic        push;

    // Accept whenever the queue has room; the back drains it independently.
    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    utf8pc_front u_front (
        .data_byte (data_byte),
        .last_byte (last_byte),
        .cls       (cls)
    );

    utf8pc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cls (cls),
        .full     (q_full),
        .pop      (pop),
        .head     (head)
    );

    utf8pc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .utf8_valid  (utf8_valid),
        .ascii_valid (ascii_valid),
        .printable   (printable)
    );

endmodule

// ===== hdl/utf8pc_checker.sv =====
`include "utf8_printable_checker_unit_defines.svh"

module utf8pc_checker
    import utf8pc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] data_byte,
    input logic       last_byte,
    input logic       out_valid,
    input logic       out_ready,
    input logic       utf8_valid,
    input logic       ascii_valid,
    input logic       printable
);

    localparam int OUTST_MAX = QUEUE_DEPTH + 1;
    localparam int OUTST_W   = $clog2(OUTST_MAX + 1);

    logic               msg_in;
    logic               msg_out;
    logic [OUTST_W-1:0] outst_reg;
    logic [OUTST_W-1:0] outst_next;

    // Count messages whose final byte went in but whose verdict has not left.
    assign msg_in     = in_valid && in_ready && last_byte;
    assign msg_out    = out_valid && out_ready;
    assign outst_next = outst_reg + OUTST_W'(msg_in) - OUTST_W'(msg_out);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outst_reg <= '0;
        end
        else
        begin
            outst_reg <= outst_next;
        end
    end

    `UTF8PC_ASSERT(a_out_hold,
        out_valid && !out_ready |=> out_valid && $stable({utf8_valid, ascii_valid, printable}),
        "result changed or dropped while stalled")
    `UTF8PC_ASSERT(a_no_extra_result,
        out_valid |-> outst_reg != '0,
        "result without a completed message")
    `UTF8PC_ASSERT(a_backlog_full,
        outst_reg == OUTST_W'(OUTST_MAX) |-> !in_ready,
        "input taken with every stage holding a message")
    // Skip the first edge of reset.
    `UTF8PC_ASSERT_ALWAYS(a_reset_quiet,
        !rst_n && $past(!rst_n) |-> !out_valid,
        "result shown during reset")

endmodule

bind utf8_printable_checker_unit utf8pc_checker u_checker (.*);

// ===== tb/tb_top.sv =====
module tb_top;
    import utf8pc_pkg::*;

    // Watchdog.
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int RANDOM_BYTES = 1150;
    localparam int DRAIN_CYCLES = 8;

    // One verdict as the block reports it on the output channel.
    typedef struct packed {
        logic utf8_ok;
        logic ascii_ok;
        logic print_ok;
    } verdict_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       out_valid;
    logic       out_ready;
    logic       utf8_valid;
    logic       ascii_valid;
    logic       printable;

    utf8_printable_checker_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .utf8_valid  (utf8_valid),
        .ascii_valid (ascii_valid),
        .printable   (printable)
    );

    // Verdicts predicted but not yet seen on the output channel, oldest first.
    verdict_t   verdict_q[$];
    // Message being assembled by the current test.
    logic [7:0] msg_buf[$];

    // When set, both sides run without idle cycles.
    bit full_speed;

    int mismatch_count;
    int bytes_sent;
    int messages_sent;
    int utf8_ok_seen;
    int ascii_ok_seen;
    int print_ok_seen;
    int cycle_count;

    // Predictor state: the UTF-8 sequence in progress, the sticky error flags
    // and the prefix probe.
    logic [1:0] seq_left;
    logic [7:0] seq_lead;
    bit         seq_second_bf;
    bit         utf8_bad;
    bit         ascii_bad;
    bit         prefix_high;
    int         prefix_seen;

    //------------------------------------------------------------------
    // Clock, watchdog
    //------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------
    function automatic void clear_message_state();
        seq_left      = 2'd0;
        seq_lead      = 8'h00;
        seq_second_bf = 1'b0;
        utf8_bad      = 1'b0;
        ascii_bad     = 1'b0;
        prefix_high   = 1'b0;
        prefix_seen   = 0;
    endfunction

    // Advance the UTF-8 sequence tracker by one byte.
    function automatic void track_utf8(input logic [7:0] b);
        int seq_total;
        int seq_pos;
        if (seq_left != 2'd0)
        begin
            // Expect a continuation; anything else drops the open sequence.
            if ((b & 8'hC0) != 8'h80)
            begin
                utf8_bad = 1'b1;
                seq_left = 2'd0;
                return;
            end
            if ((seq_lead & 8'hE0) == 8'hC0)
                seq_total = 1;
            else if ((seq_lead & 8'hF0) == 8'hE0)
                seq_total = 2;
            else
                seq_total = 3;
            seq_pos = seq_total - int'(seq_left);
            if (seq_pos == 0)
            begin
                // Second byte: overlong, surrogate and range guards.
                if (seq_lead == 8'hE0 && (b & 8'hE0) == 8'h80)
                    utf8_bad = 1'b1;
                if (seq_lead == 8'hED && (b & 8'hE0) == 8'hA0)
                    utf8_bad = 1'b1;
                if (seq_lead == 8'hF0 && (b & 8'hF0) == 8'h80)
                    utf8_bad = 1'b1;
                if (seq_lead == 8'hF4 && b > 8'h8F)
                    utf8_bad = 1'b1;
                seq_second_bf = (b == 8'hBF);
            end
            else if (seq_pos == 1 && seq_total == 2)
            begin
                // EF BF BE and EF BF BF are the noncharacters U+FFFE and U+FFFF.
                if (seq_lead == 8'hEF && seq_second_bf && (b & 8'hFE) == 8'hBE)
                    utf8_bad = 1'b1;
            end
            seq_left = seq_left - 2'd1;
            return;
        end
        if (b < 8'h80)
            return;
        if ((b & 8'hE0) == 8'hC0)
        begin
            if ((b & 8'hFE) == 8'hC0)
            begin
                utf8_bad = 1'b1;
                return;
            end
            seq_left = 2'd1;
        end
        else if ((b & 8'hF0) == 8'hE0)
            seq_left = 2'd2;
        else if ((b & 8'hF8) == 8'hF0 && b <= 8'hF4)
            seq_left = 2'd3;
        else
        begin
            utf8_bad = 1'b1;
            return;
        end
        seq_lead      = b;
        seq_second_bf = 1'b0;
    endfunction

    // Fold one accepted byte into the message state; on the final byte queue
    // the verdict and start over.
    function automatic void absorb_byte(input logic [7:0] b, input logic last);
        verdict_t v;
        if (b < 8'h20 || b > 8'h7E)
            ascii_bad = 1'b1;
        if (prefix_seen < PREFIX_PROBE_LEN)
        begin
            if (b >= 8'h80)
                prefix_high = 1'b1;
            prefix_seen++;
        end
        track_utf8(b);
        if (!last)
            return;
        if (seq_left != 2'd0)
            utf8_bad = 1'b1;
        v.utf8_ok  = !utf8_bad;
        v.ascii_ok = !ascii_bad;
        v.print_ok = v.ascii_ok || (prefix_high && v.utf8_ok);
        verdict_q.push_back(v);
        clear_message_state();
    endfunction

    //------------------------------------------------------------------
    // Input side
    //------------------------------------------------------------------
    function automatic int draw_gap();
        return full_speed ? 0 : int'($urandom_range(0, 10));
    endfunction

    // Send one byte. Callers chain these with no time in between, so valid
    // stays high across back-to-back transactions; drop_valid ends a burst.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        data_byte = b;
        last_byte = last;
        // Hold the transaction until the block takes it.
        do
            @(posedge clk);
        while (!in_ready);
        absorb_byte(b, last);
        bytes_sent++;
        if (last)
            messages_sent++;
    endtask

    task automatic send_message();
        for (int i = 0; i < msg_buf.size(); i++)
            send_byte(msg_buf[i], i == msg_buf.size() - 1);
    endtask

    task automatic drop_valid();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    //------------------------------------------------------------------
    // Output side: random stalls, then check each transaction
    //------------------------------------------------------------------
    task automatic compare_bit(input string field, input logic expected, input logic actual);
        if (expected !== actual)
        begin
            $display("%0t: %s mismatch, expected %0b, actual %0b",
                     $time, field, expected, actual);
            mismatch_count++;
        end
    endtask

    initial
    begin
        int       stall;
        verdict_t v;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_gap();
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            if (verdict_q.size() == 0)
            begin
                $display("%0t: verdict with none expected, actual utf8=%0b ascii=%0b print=%0b",
                         $time, utf8_valid, ascii_valid, printable);
                mismatch_count++;
            end
            else
            begin
                v = verdict_q.pop_front();
                compare_bit("utf8_valid", v.utf8_ok, utf8_valid);
                compare_bit("ascii_valid", v.ascii_ok, ascii_valid);
                compare_bit("printable", v.print_ok, printable);
                utf8_ok_seen  += int'(utf8_valid === 1'b1);
                ascii_ok_seen += int'(ascii_valid === 1'b1);
                print_ok_seen += int'(printable === 1'b1);
            end
        end
    end

    //------------------------------------------------------------------
    // Random message content
    //------------------------------------------------------------------
    // Append the UTF-8 encoding of cp; values past U+10FFFF still get a
    // four-byte form, so out-of-range leads and second bytes can reach the block.
    function automatic void put_code_point(input int unsigned cp);
        if (cp < 32'h80)
            msg_buf.push_back(cp[7:0]);
        else if (cp < 32'h800)
        begin
            msg_buf.push_back(8'hC0 | 8'(cp >> 6));
            msg_buf.push_back(8'h80 | 8'(cp & 32'h3F));
        end
        else if (cp < 32'h10000)
        begin
            msg_buf.push_back(8'hE0 | 8'(cp >> 12));
            msg_buf.push_back(8'h80 | 8'((cp >> 6) & 32'h3F));
            msg_buf.push_back(8'h80 | 8'(cp & 32'h3F));
        end
        else
        begin
            msg_buf.push_back(8'hF0 | 8'((cp >> 18) & 32'h7));
            msg_buf.push_back(8'h80 | 8'((cp >> 12) & 32'h3F));
            msg_buf.push_back(8'h80 | 8'((cp >> 6) & 32'h3F));
            msg_buf.push_back(8'h80 | 8'(cp & 32'h3F));
        end
    endfunction

    function automatic int unsigned pick_code_point();
        int unsigned edges[13] = '{32'h80, 32'h7FF, 32'h800, 32'hD7FF, 32'hD800,
                                   32'hDFFF, 32'hE000, 32'hFFFD, 32'hFFFE, 32'hFFFF,
                                   32'h10000, 32'h10FFFF, 32'h110000};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(32'h20, 32'h7E);
            4:          return $urandom_range(0, 32'h7F);
            5:          return $urandom_range(32'h80, 32'h7FF);
            6, 7:       return $urandom_range(32'h800, 32'hFFFF);
            8:          return $urandom_range(32'h10000, 32'h10FFFF);
            default:    return edges[$urandom_range(0, 12)];
        endcase
    endfunction

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------
    // Printable range edges, control bytes, and the all-ASCII printable rule.
    task automatic test_ascii_edges();
        msg_buf = {8'h20};
        send_message();
        msg_buf = {8'h7E, 8'h1F};
        send_message();
        msg_buf = {8'h7F, 8'h00};
        send_message();
    endtask

    // Stray continuation, overlong two-byte lead and a byte never legal in UTF-8.
    task automatic test_bad_leads();
        msg_buf = {8'h80};
        send_message();
        msg_buf = {8'hC1};
        send_message();
        msg_buf = {8'hFF};
        send_message();
    endtask

    // Second-byte guards on E0, ED, F0, F4 and the U+FFFE / U+FFFF noncharacters.
    task automatic test_guarded_sequences();
        msg_buf = {8'hE0, 8'h9F, 8'hBF};
        send_message();
        msg_buf = {8'hED, 8'hA0, 8'h80};
        send_message();
        msg_buf = {8'hEF, 8'hBF, 8'hBE};
        send_message();
        msg_buf = {8'hEF, 8'hBF, 8'hBF};
        send_message();
        msg_buf = {8'hF0, 8'h8F, 8'hBF, 8'hBF};
        send_message();
        msg_buf = {8'hF4, 8'h90, 8'h80, 8'h80};
        send_message();
        // Highest legal code point, U+10FFFF.
        msg_buf = {8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_message();
    endtask

    // Missing continuation with parsing resumed after it, and a sequence
    // still open on the final byte.
    task automatic test_cut_short();
        msg_buf = {8'hC3, 8'h41};
        send_message();
        msg_buf = {8'h41, 8'hE2, 8'h82};
        send_message();
    endtask

    // Mostly well-formed text with random content and a varying ASCII lead-in
    // (to move the first high byte across the prefix window), plus broken
    // sequences and raw noise.
    task automatic test_random_messages();
        int start_bytes;
        int style;
        int units;
        int pos;
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < RANDOM_BYTES)
        begin
            full_speed = ($urandom_range(0, 5) == 0);
            style      = $urandom_range(0, 9);
            units      = $urandom_range(1, 10);
            msg_buf.delete();
            if (style < 2)
            begin
                for (int i = 0; i < units; i++)
                    msg_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
            end
            else if (style < 9)
            begin
                repeat ($urandom_range(0, 6))
                    msg_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
                for (int i = 0; i < units; i++)
                    put_code_point(pick_code_point());
                if (style >= 7)
                begin
                    pos = $urandom_range(0, msg_buf.size() - 1);
                    case ($urandom_range(0, 2))
                        0: msg_buf[pos] = 8'($urandom_range(0, 255));
                        1: msg_buf.insert(pos, 8'($urandom_range(8'h80, 8'hBF)));
                        default:
                            if (msg_buf.size() > 1)
                                void'(msg_buf.pop_back());
                    endcase
                end
            end
            else
            begin
                for (int i = 0; i < units; i++)
                    msg_buf.push_back(8'($urandom_range(0, 255)));
            end
            send_message();
        end
    endtask

    //------------------------------------------------------------------
    // Sequencer
    //------------------------------------------------------------------
    initial
    begin
        // Drive every input to a known value and hold reset low.
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        data_byte      = 8'h00;
        last_byte      = 1'b0;
        full_speed     = 1'b0;
        mismatch_count = 0;
        bytes_sent     = 0;
        messages_sent  = 0;
        utf8_ok_seen   = 0;
        ascii_ok_seen  = 0;
        print_ok_seen  = 0;
        cycle_count    = 0;
        clear_message_state();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_ascii_edges();
        test_bad_leads();
        test_guarded_sequences();
        test_cut_short();
        test_random_messages();
        drop_valid();

        // Drain outstanding verdicts, then give the pipeline time to show
        // anything extra; the watchdog bounds the wait.
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes in %0d messages, incl. overlong, surrogate, range and cut-short",
                 bytes_sent, messages_sent);
        $display("Verdicts high: utf8 %0d, ascii %0d, printable %0d; mismatches %0d",
                 utf8_ok_seen, ascii_ok_seen, print_ok_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== utf8_printable_checker_unit.f =====
+incdir+hdl
hdl/utf8pc_pkg.sv
hdl/utf8pc_front.sv
hdl/utf8pc_queue.sv
hdl/utf8pc_back.sv
hdl/utf8_printable_checker_unit.sv
hdl/utf8pc_checker.sv
tb/tb_top.sv
